@@ rtl/pulse_width_frame_receiver_macros.svh @@
// assertion helpers for the pulse width frame receiver
// each macro expects clk and rst_n in the scope where it is used
`ifndef PULSE_WIDTH_FRAME_RECEIVER_MACROS_SVH
`define PULSE_WIDTH_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define PWFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwfr assertion failed");

// next-cycle implication
`define PWFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwfr assertion failed");

`else

`define PWFR_ASSERT_IMPL(label, ante, cons)
`define PWFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/pwfr_pkg.sv @@
package pwfr_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FRAME_HEADER   = 3'd0,
    REG_OWN_ADDRESS    = 3'd1,
    REG_UNLOCK_COMMAND = 3'd2,
    REG_SHORT_MIN      = 3'd3,
    REG_LONG_MIN       = 3'd4,
    REG_ACTIVE_WRAP    = 3'd5,
    REG_IDLE_LIMIT     = 3'd6
  } cfg_idx_t;

  // frame position codes
  typedef enum logic [1:0] {
    FRM_HEADER  = 2'd0,
    FRM_ADDRESS = 2'd1,
    FRM_COMMAND = 2'd2,
    FRM_UNUSED  = 2'd3
  } frame_pos_t;

  // reset values of the configuration registers
  localparam logic [7:0] RST_FRAME_HEADER   = 8'd0;
  localparam logic [7:0] RST_OWN_ADDRESS    = 8'd0;
  localparam logic [7:0] RST_UNLOCK_COMMAND = 8'd0;
  localparam logic [7:0] RST_SHORT_MIN      = 8'd20;
  localparam logic [7:0] RST_LONG_MIN       = 8'd80;
  localparam logic [7:0] RST_ACTIVE_WRAP    = 8'd150;
  localparam logic [7:0] RST_IDLE_LIMIT     = 8'd100;

  // bits per byte as counted by the bit position
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // configuration seen by the decode stage
  typedef struct packed {
    logic [7:0] frame_header;
    logic [7:0] own_address;
    logic [7:0] unlock_command;
    logic [7:0] short_pulse_min;
    logic [7:0] long_pulse_min;
    logic [7:0] active_wrap_limit;
    logic [7:0] idle_limit;
  } cfg_t;

endpackage

@@ rtl/pwfr_cfg_regs.sv @@
module pwfr_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_addr,
  input  logic [7:0]      cfg_wdata,
  output pwfr_pkg::cfg_t  cfg
);

  pwfr_pkg::cfg_t cfg_r;
  pwfr_pkg::cfg_t cfg_nxt;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (pwfr_pkg::cfg_idx_t'(cfg_addr))
        pwfr_pkg::REG_FRAME_HEADER:   cfg_nxt.frame_header      = cfg_wdata;
        pwfr_pkg::REG_OWN_ADDRESS:    cfg_nxt.own_address       = cfg_wdata;
        pwfr_pkg::REG_UNLOCK_COMMAND: cfg_nxt.unlock_command    = cfg_wdata;
        pwfr_pkg::REG_SHORT_MIN:      cfg_nxt.short_pulse_min   = cfg_wdata;
        pwfr_pkg::REG_LONG_MIN:       cfg_nxt.long_pulse_min    = cfg_wdata;
        pwfr_pkg::REG_ACTIVE_WRAP:    cfg_nxt.active_wrap_limit = cfg_wdata;
        pwfr_pkg::REG_IDLE_LIMIT:     cfg_nxt.idle_limit        = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // register bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_header      <= pwfr_pkg::RST_FRAME_HEADER;
      cfg_r.own_address       <= pwfr_pkg::RST_OWN_ADDRESS;
      cfg_r.unlock_command    <= pwfr_pkg::RST_UNLOCK_COMMAND;
      cfg_r.short_pulse_min   <= pwfr_pkg::RST_SHORT_MIN;
      cfg_r.long_pulse_min    <= pwfr_pkg::RST_LONG_MIN;
      cfg_r.active_wrap_limit <= pwfr_pkg::RST_ACTIVE_WRAP;
      cfg_r.idle_limit        <= pwfr_pkg::RST_IDLE_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/pwfr_in_reg.sv @@
module pwfr_in_reg (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic line_level,
  output logic smp_valid,
  input  logic smp_ready,
  output logic smp_level
);

  logic valid_r;
  logic valid_nxt;
  logic level_r;
  logic load;

  // the register refills in the same cycle it drains
  assign in_tready = !valid_r || smp_ready;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (smp_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // sample payload
  always_ff @(posedge clk) begin
    if (load) begin
      level_r <= line_level;
    end
  end

  assign smp_valid = valid_r;
  assign smp_level = level_r;

endmodule

@@ rtl/pwfr_decode.sv @@
`include "pulse_width_frame_receiver_macros.svh"

module pwfr_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  pwfr_pkg::cfg_t cfg,
  input  logic           smp_valid,
  output logic           smp_ready,
  input  logic           smp_level,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           lock_enable,
  output logic           byte_valid,
  output logic [7:0]     byte_value,
  output logic           frame_done
);

  // receiver state
  logic                 armed_r,  armed_nxt;
  logic [7:0]           active_r, active_nxt;
  logic [7:0]           idle_r,   idle_nxt;
  logic [7:0]           shift_r,  shift_nxt;
  logic [3:0]           bitpos_r, bitpos_nxt;
  pwfr_pkg::frame_pos_t frame_r,  frame_nxt;
  logic                 lock_r,   lock_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic       out_byte_valid_r;
  logic [7:0] out_byte_value_r;
  logic       out_frame_done_r;

  logic       fire;
  logic       res_valid;
  logic [7:0] res_value;
  logic       res_done;
  logic [7:0] act_inc;
  logic [7:0] idle_inc;
  logic       is_bit0;
  logic       is_bit1;

  assign smp_ready = !out_valid_r || out_ready;
  assign fire      = smp_valid && smp_ready;

  assign act_inc  = 8'(active_r + 8'd1);
  assign idle_inc = 8'(idle_r + 8'd1);
  assign is_bit0  = (active_r > cfg.short_pulse_min) && (active_r <= cfg.long_pulse_min);
  assign is_bit1  = active_r > cfg.long_pulse_min;

  // one tick of pulse timing, bit assembly and frame matching
  always_comb begin
    armed_nxt  = armed_r;
    active_nxt = active_r;
    idle_nxt   = idle_r;
    shift_nxt  = shift_r;
    bitpos_nxt = bitpos_r;
    frame_nxt  = frame_r;
    lock_nxt   = lock_r;
    res_valid  = 1'b0;
    res_value  = 8'd0;
    res_done   = 1'b0;

    if (smp_level) begin
      // pulse active: count with wrap at the limit
      armed_nxt  = 1'b0;
      active_nxt = (act_inc == cfg.active_wrap_limit) ? 8'd0 : act_inc;
    end else if (!armed_r) begin
      // release edge: classify the pulse
      armed_nxt  = 1'b1;
      active_nxt = 8'd0;
      if (is_bit1) begin
        shift_nxt  = {shift_r[6:0], 1'b1};
        bitpos_nxt = 4'(bitpos_r + 4'd1);
        idle_nxt   = 8'd0;
      end else if (is_bit0) begin
        // idle count restarts at one after a zero bit
        shift_nxt  = {shift_r[6:0], 1'b0};
        bitpos_nxt = 4'(bitpos_r + 4'd1);
        idle_nxt   = 8'd1;
      end else begin
        idle_nxt = idle_inc;
      end
    end else begin
      // line idle: timeout drops framing and relocks
      idle_nxt = idle_inc;
      if (idle_inc >= cfg.idle_limit) begin
        bitpos_nxt = 4'd0;
        frame_nxt  = pwfr_pkg::FRM_HEADER;
        lock_nxt   = 1'b1;
      end
    end

    // byte complete: step the frame matcher
    if (bitpos_nxt == pwfr_pkg::BITS_PER_BYTE) begin
      bitpos_nxt = 4'd0;
      res_valid  = 1'b1;
      res_value  = shift_nxt;
      unique case (frame_nxt)
        pwfr_pkg::FRM_HEADER: begin
          frame_nxt = (shift_nxt == cfg.frame_header) ?
                      pwfr_pkg::FRM_ADDRESS : pwfr_pkg::FRM_HEADER;
        end
        pwfr_pkg::FRM_ADDRESS: begin
          frame_nxt = (shift_nxt == cfg.own_address) ?
                      pwfr_pkg::FRM_COMMAND : pwfr_pkg::FRM_HEADER;
        end
        pwfr_pkg::FRM_COMMAND: begin
          frame_nxt = pwfr_pkg::FRM_HEADER;
          res_done  = 1'b1;
          if (shift_nxt == cfg.unlock_command) begin
            lock_nxt = 1'b0;
          end
        end
        default: frame_nxt = pwfr_pkg::FRM_HEADER;
      endcase
    end
  end

  // state registers advance once per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b1;
      active_r <= 8'd0;
      idle_r   <= 8'd0;
      shift_r  <= 8'd0;
      bitpos_r <= 4'd0;
      frame_r  <= pwfr_pkg::FRM_HEADER;
      lock_r   <= 1'b1;
    end else if (fire) begin
      armed_r  <= armed_nxt;
      active_r <= active_nxt;
      idle_r   <= idle_nxt;
      shift_r  <= shift_nxt;
      bitpos_r <= bitpos_nxt;
      frame_r  <= frame_nxt;
      lock_r   <= lock_nxt;
    end
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_valid_r <= res_valid;
      out_byte_value_r <= res_value;
      out_frame_done_r <= res_done;
    end
  end

  assign out_valid   = out_valid_r;
  assign lock_enable = lock_r;
  assign byte_valid  = out_byte_valid_r;
  assign byte_value  = out_byte_value_r;
  assign frame_done  = out_frame_done_r;

  `PWFR_ASSERT_IMPL(a_done_has_byte, out_valid_r && out_frame_done_r, out_byte_valid_r)
  `PWFR_ASSERT_IMPL(a_value_zero_no_byte, out_valid_r && !out_byte_valid_r, out_byte_value_r == 8'd0)
  `PWFR_ASSERT_IMPL(a_bitpos_below_byte, 1'b1, bitpos_r < pwfr_pkg::BITS_PER_BYTE)
  `PWFR_ASSERT_IMPL(a_frame_pos_reachable, 1'b1, frame_r != pwfr_pkg::FRM_UNUSED)
  `PWFR_ASSERT_NEXT(a_unlock_needs_frame, fire && lock_r && !lock_nxt, out_frame_done_r)

endmodule

@@ rtl/pulse_width_frame_receiver.sv @@
// pulse width frame receiver
// input stream: one beat per timer tick, in_tdata[0] is the sampled line level
// (1 = pulse active). pulses are timed, classified as bit 0 or bit 1 on release,
// and assembled msb first into bytes; header, address, command frames are matched
// output stream: exactly one beat per input beat, in order. out_tdata[0] is the
// lock drive, out_tdata[8:1] the completed byte, out_tuser flags a completed byte
// and out_tlast marks the command byte that ends a frame
// configuration: cfg_we writes cfg_wdata to register cfg_addr (0 header,
// 1 address, 2 unlock command, 3 short min, 4 long min, 5 active wrap,
// 6 idle limit); write only while no beat is in flight
// latency: a beat accepted at one clock edge is on the output after the next edge
// throughput: one beat per cycle; the single-cycle state update between the input
// register and the result register sets this rate
// reset: holding rst_n low for one edge empties both registers, loads the register
// defaults and sets the lock drive to 1
// stall: while out_tready is low the result holds; the input register takes at most
// one more beat, then in_tready drops until the result is taken
module pulse_width_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] line_level, [7:1] zero
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] lock_enable, [8:1] byte_value, [15:9] zero
  output logic        out_tuser,  // [0] byte_valid
  output logic        out_tlast   // frame_done
);

  pwfr_pkg::cfg_t cfg;
  logic           smp_valid;
  logic           smp_ready;
  logic           smp_level;
  logic           lock_enable;
  logic [7:0]     byte_value;

  pwfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pwfr_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .line_level (in_tdata[0]),
    .smp_valid  (smp_valid),
    .smp_ready  (smp_ready),
    .smp_level  (smp_level)
  );

  pwfr_decode u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .smp_valid   (smp_valid),
    .smp_ready   (smp_ready),
    .smp_level   (smp_level),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .lock_enable (lock_enable),
    .byte_valid  (out_tuser),
    .byte_value  (byte_value),
    .frame_done  (out_tlast)
  );

  // pack the result beat
  assign out_tdata = {7'd0, byte_value, lock_enable};

endmodule
